[src/pvi_pkg.sv]
// pvi_pkg: shared types, constants and helpers for the variable integral weight pid core
// used by pvi_regs, pvi_mul and pid_variable_integral_weight_core
package pvi_pkg;

  localparam int ERR_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BETA_W     = 11;
  localparam int GAIN_FRAC  = 8;
  localparam int BETA_FRAC  = 10;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 27;
  localparam int MAG_W      = ERR_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd4;

  // reset values
  localparam logic [GAIN_W-1:0] RST_GAIN_P      = 16'd12800;
  localparam logic [GAIN_W-1:0] RST_GAIN_I      = 16'd1920;
  localparam logic [GAIN_W-1:0] RST_GAIN_D      = 16'd640;
  localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT = 15'd400;
  localparam logic [LIM_W-1:0]  RST_OUT_LIMIT   = 15'd5000;

  // integral weight, q1.10
  localparam logic [BETA_W-1:0] BETA_ZERO = 11'd0;
  localparam logic [BETA_W-1:0] BETA_LOW  = 11'd614;
  localparam logic [BETA_W-1:0] BETA_MID  = 11'd922;
  localparam logic [BETA_W-1:0] BETA_ONE  = 11'd1024;

  localparam logic [MAG_W-1:0] BAND_ZERO = 17'd60;
  localparam logic [MAG_W-1:0] BAND_LOW  = 17'd20;
  localparam logic [MAG_W-1:0] BAND_MID  = 17'd10;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  integ_limit;
    logic [LIM_W-1:0]  out_limit;
  } pvi_cfg_t;

  function automatic logic [BETA_W-1:0] beta_sel(input logic signed [ERR_W-1:0] e);
    logic [MAG_W-1:0] ext;
    logic [MAG_W-1:0] mag;
    logic [BETA_W-1:0] b;
    ext = {e[ERR_W-1], e};
    // -32768 gives a magnitude of 32768
    mag = e[ERR_W-1] ? MAG_W'(-ext) : ext;
    if (mag > BAND_ZERO) b = BETA_ZERO;
    else if (mag > BAND_LOW) b = BETA_LOW;
    else if (mag > BAND_MID) b = BETA_MID;
    else b = BETA_ONE;
    return b;
  endfunction

endpackage

[src/pid_variable_integral_weight_core.sv]
// pid core with integral separation: one error sample in, one saturated drive out
// after the accepting edge the sequencer walks S_P, S_D, S_I1, S_I2, S_ACC and S_SAT, one
// sample at a time: four passes through the single shared multiplier, accumulate, saturate
// a new sample is taken while the previous drive still waits in the output register
// reset (synchronous, rst_n low): gains and limits to defaults, integrator and
// previous error to zero, sequencer idle, no output pending
module pid_variable_integral_weight_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pvi_pkg::ERR_W-1:0]      in_err_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pvi_pkg::ERR_W-1:0]      out_drive_value,
  input  logic                                  cfg_we,
  input  logic [pvi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pvi_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pvi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_P, S_D, S_I1, S_I2, S_ACC, S_SAT
  } state_t;

  state_t                   state_r;
  pvi_cfg_t                 cfg;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  integ_r;
  logic [BETA_W-1:0]        beta_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic signed [ERR_W-1:0]  out_drive_r;

  logic signed [MAG_W-1:0]  integ_sum;
  logic signed [MAG_W-1:0]  integ_ext;
  logic signed [MAG_W-1:0]  ilim_s;
  logic signed [ERR_W-1:0]  integ_clamped;
  logic signed [MAG_W-1:0]  err_diff;
  logic signed [ACC_W-1:0]  olim_s;
  logic signed [ERR_W-1:0]  drive_clamped;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    term_g;
  logic signed [ACC_W-1:0]    term_b;

  pvi_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pvi_mul u_mul (
    .clk   (clk),
    .en    (mul_en),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  // integrator update and clamp
  always_comb begin
    integ_ext = MAG_W'(integ_r);
    ilim_s    = signed'({2'b00, cfg.integ_limit});
    integ_sum = integ_ext + MAG_W'(err_r);
    if (integ_sum > ilim_s) integ_clamped = ERR_W'(ilim_s);
    else if (integ_sum < -ilim_s) integ_clamped = ERR_W'(-ilim_s);
    else integ_clamped = integ_sum[ERR_W-1:0];
  end

  assign err_diff = MAG_W'(err_r) - MAG_W'(prev_err_r);

  // floor shifts of the product by the gain and weight fractions
  assign term_g = signed'(prod[ACC_W+GAIN_FRAC-1:GAIN_FRAC]);
  assign term_b = signed'(prod[ACC_W+BETA_FRAC-1:BETA_FRAC]);

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_P: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = signed'({1'b0, cfg.gain_p});
      end
      S_D: begin
        mul_a = MUL_A_W'(err_diff);
        mul_b = signed'({1'b0, cfg.gain_d});
      end
      S_I1: begin
        mul_a = MUL_A_W'(integ_r);
        mul_b = signed'({1'b0, cfg.gain_i});
      end
      S_I2: begin
        mul_a = signed'(prod[MUL_A_W+GAIN_FRAC-1:GAIN_FRAC]);
        mul_b = signed'(MUL_B_W'(beta_r));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // output saturation
  always_comb begin
    olim_s = signed'(ACC_W'(cfg.out_limit));
    if (acc_r > olim_s) drive_clamped = ERR_W'(olim_s);
    else if (acc_r < -olim_s) drive_clamped = ERR_W'(-olim_s);
    else drive_clamped = acc_r[ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_err_r  <= '0;
    end else begin
      // in S_SAT the sequencer itself decides the output valid
      if (out_valid_r && out_ready && state_r != S_SAT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            err_r   <= in_err_sample;
            beta_r  <= beta_sel(in_err_sample);
            state_r <= S_P;
          end
        end
        S_P: begin
          integ_r <= integ_clamped;
          state_r <= S_D;
        end
        S_D: begin
          acc_r      <= term_g;
          prev_err_r <= err_r;
          state_r    <= S_I1;
        end
        S_I1: begin
          acc_r   <= acc_r + term_g;
          state_r <= S_I2;
        end
        S_I2: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + term_b;
          state_r <= S_SAT;
        end
        S_SAT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_drive_r <= drive_clamped;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_P)
    else $error("accepted transaction did not start the sequence");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_I1 |-> (integ_ext <= ilim_s) && (integ_ext >= -ilim_s))
    else $error("integrator outside its clamp bound");

  a_beta_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> beta_r == BETA_ZERO || beta_r == BETA_LOW ||
      beta_r == BETA_MID || beta_r == BETA_ONE)
    else $error("integral weight is not a band value");

  a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ACC_W'(out_drive_r) <= olim_s) && (ACC_W'(out_drive_r) >= -olim_s))
    else $error("drive outside its saturation bound");
`endif

endmodule

[src/pvi_regs.sv]
// pvi_regs: configuration registers (gains and limits) with their reset values
// depends on pvi_pkg
module pvi_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pvi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvi_pkg::CFG_DATA_W-1:0] cfg_data,
  output pvi_pkg::pvi_cfg_t              cfg
);
  import pvi_pkg::*;

  pvi_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= RST_GAIN_P;
      cfg_r.gain_i      <= RST_GAIN_I;
      cfg_r.gain_d      <= RST_GAIN_D;
      cfg_r.integ_limit <= RST_INTEG_LIMIT;
      cfg_r.out_limit   <= RST_OUT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:      cfg_r.gain_p      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:      cfg_r.gain_i      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:      cfg_r.gain_d      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_r.integ_limit <= cfg_data[LIM_W-1:0];
        REG_OUT_LIMIT:   cfg_r.out_limit   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/pvi_mul.sv]
// pvi_mul: shared signed multiplier with registered product
// depends on pvi_pkg
module pvi_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [pvi_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [pvi_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [pvi_pkg::PROD_W-1:0]  prod
);
  import pvi_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  assign prod = prod_r;

endmodule
